/* hdl/dasc_pkg.sv */
package dasc_pkg;

  localparam int LINE_BITS_DEFAULT   = 20;
  localparam int COLUMN_BITS_DEFAULT = 16;
  localparam int DEPTH_BITS_DEFAULT  = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int CHAR_BITS           = 21;
  localparam int OP_BITS             = 2;
  localparam int CLS_BITS            = 4;

  typedef enum logic [OP_BITS-1:0] {
    OP_START    = 2'd0,
    OP_CHAR     = 2'd1,
    OP_LINE_END = 2'd2,
    OP_TEXT_END = 2'd3
  } op_t;

  typedef enum logic [CLS_BITS-1:0] {
    CL_OTHER  = 4'd0,
    CL_SPACE  = 4'd1,
    CL_HASH   = 4'd2,
    CL_BSLASH = 4'd3,
    CL_DQUOTE = 4'd4,
    CL_SQUOTE = 4'd5,
    CL_OPEN   = 4'd6,
    CL_CLOSE  = 4'd7,
    CL_EQUAL  = 4'd8,
    CL_COLON  = 4'd9
  } cls_t;

  typedef struct packed {
    logic       searching;
    logic       in_triple;
    logic       triple_dq;
    logic       in_plain;
    logic       plain_dq;
    logic       escape;
    logic [1:0] skip;
    logic       in_comment;
    logic       continued;
    logic       line_bs;
    logic       line_token;
    logic       last_colon;
    logic       colon_valid;
  } scan_flags_t;

endpackage

/* hdl/declaration_assignment_scanner.sv */
// channel  dir  tdata                                       tuser
// s_axis   in   char_code, begin_line, begin_column         op
// m_axis   out  found, equal_line, equal_column, inferred,  -
//               colon_seen, colon_line_out, colon_column_out
//
// one word per cycle while the queue has room; a line end or text end waits at
// the queue head while each held character (up to two) goes through the scanner
// a small queue parts the classifier from the scanner, a result register parts
// the scanner from the output, so input is taken while a result waits
// rst is synchronous and clears the queue, scanner state and result valid flag
module declaration_assignment_scanner
  import dasc_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEFAULT,
  localparam int IN_BITS    = CHAR_BITS + LINE_BITS + COLUMN_BITS,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 3 + 2 * LINE_BITS + 2 * COLUMN_BITS,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // char_code, begin_line, begin_column
  input  logic [IN_W-1:0]    s_tdata,
  // op
  input  logic [OP_BITS-1:0] s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // found, equal_line, equal_column, inferred, colon_seen, colon_line_out,
  // colon_column_out
  output logic [OUT_W-1:0]   m_tdata
);

  localparam int Q_W = OP_BITS + CLS_BITS + LINE_BITS + COLUMN_BITS;

  cls_t                   cls;
  logic [Q_W-1:0]         q_in;
  logic [Q_W-1:0]         q_out;
  logic                   q_valid;
  logic                   q_pop;
  logic                   found;
  logic [LINE_BITS-1:0]   equal_line;
  logic [COLUMN_BITS-1:0] equal_column;
  logic                   inferred;
  logic                   colon_seen;
  logic [LINE_BITS-1:0]   colon_ln_out;
  logic [COLUMN_BITS-1:0] colon_col_out;

  dasc_front u_front (
    .char_code (s_tdata[CHAR_BITS-1:0]),
    .cls       (cls)
  );

  assign q_in = {s_tdata[IN_BITS-1:CHAR_BITS], cls, s_tuser};

  dasc_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH_DEFAULT)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (q_in),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_out)
  );

  dasc_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_valid),
    .head_pop      (q_pop),
    .head_op       (op_t'(q_out[OP_BITS-1:0])),
    .head_cls      (cls_t'(q_out[OP_BITS+CLS_BITS-1:OP_BITS])),
    .head_line     (q_out[OP_BITS+CLS_BITS+LINE_BITS-1:OP_BITS+CLS_BITS]),
    .head_column   (q_out[Q_W-1:OP_BITS+CLS_BITS+LINE_BITS]),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .found         (found),
    .equal_line    (equal_line),
    .equal_column  (equal_column),
    .inferred      (inferred),
    .colon_seen    (colon_seen),
    .colon_ln_out  (colon_ln_out),
    .colon_col_out (colon_col_out)
  );

  assign m_tdata = OUT_W'({colon_col_out, colon_ln_out, colon_seen, inferred,
                           equal_column, equal_line, found});

endmodule

/* hdl/dasc_front.sv */
module dasc_front
  import dasc_pkg::*;
(
  input  logic [CHAR_BITS-1:0] char_code,
  output cls_t                 cls
);

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return c == 21'h20 || (c >= 21'h09 && c <= 21'h0D) || c == 21'h85 || c == 21'hA0 ||
           c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028 ||
           c == 21'h2029 || c == 21'h202F || c == 21'h205F || c == 21'h3000;
  endfunction

  always_comb begin
    if (is_space(char_code)) begin
      cls = CL_SPACE;
    end else begin
      case (char_code)
        21'h23:  cls = CL_HASH;
        21'h5C:  cls = CL_BSLASH;
        21'h22:  cls = CL_DQUOTE;
        21'h27:  cls = CL_SQUOTE;
        21'h28:  cls = CL_OPEN;
        21'h5B:  cls = CL_OPEN;
        21'h7B:  cls = CL_OPEN;
        21'h29:  cls = CL_CLOSE;
        21'h5D:  cls = CL_CLOSE;
        21'h7D:  cls = CL_CLOSE;
        21'h3D:  cls = CL_EQUAL;
        21'h3A:  cls = CL_COLON;
        default: cls = CL_OTHER;
      endcase
    end
  end

endmodule

/* hdl/dasc_queue.sv */
module dasc_queue
  import dasc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign in_ready  = count != CNT_BITS'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

/* hdl/dasc_back.sv */
module dasc_back
  import dasc_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  output logic                   head_pop,
  input  op_t                    head_op,
  input  cls_t                   head_cls,
  input  logic [LINE_BITS-1:0]   head_line,
  input  logic [COLUMN_BITS-1:0] head_column,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic                   found,
  output logic [LINE_BITS-1:0]   equal_line,
  output logic [COLUMN_BITS-1:0] equal_column,
  output logic                   inferred,
  output logic                   colon_seen,
  output logic [LINE_BITS-1:0]   colon_ln_out,
  output logic [COLUMN_BITS-1:0] colon_col_out
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  scan_flags_t            flags, flags_next, p_flags;
  logic [DEPTH_BITS-1:0]  nest_depth, nest_depth_next, p_depth;
  logic [LINE_BITS-1:0]   colon_ln, colon_ln_next, p_colon_ln;
  logic [COLUMN_BITS-1:0] colon_col, colon_col_next, p_colon_col;
  logic [LINE_BITS-1:0]   current_line, current_line_next;
  logic [COLUMN_BITS-1:0] current_column, current_column_next, p_col;
  cls_t                   la0, la0_next, la1, la1_next;
  logic [1:0]             la_count, la_count_next;

  logic                   step;
  logic                   take;
  logic                   emit;
  logic                   emit_found;
  logic                   p_hit;
  logic                   p_has1;
  logic                   p_has2;
  cls_t                   p_quote;

  assign step     = head_valid && (!emit || !res_valid || res_ready);
  assign head_pop = step && take;

  // one held character through the scanner rules
  always_comb begin
    p_flags     = flags;
    p_depth     = nest_depth;
    p_colon_ln  = colon_ln;
    p_colon_col = colon_col;
    p_col       = current_column + COLUMN_BITS'(1);
    p_hit       = 1'b0;
    p_has1      = (head_op == OP_CHAR) || (la_count == 2'd2);
    p_has2      = head_op == OP_CHAR;
    p_quote     = CL_SQUOTE;
    if (flags.skip != 2'd0) begin
      p_flags.skip = flags.skip - 2'd1;
    end else if (flags.in_comment) begin
      p_flags.in_comment = 1'b1;
    end else if (flags.in_plain) begin
      p_quote = flags.plain_dq ? CL_DQUOTE : CL_SQUOTE;
      if (flags.escape) begin
        p_flags.escape = 1'b0;
      end else if (la0 == CL_BSLASH) begin
        p_flags.escape = 1'b1;
      end else if (la0 == p_quote) begin
        p_flags.in_plain = 1'b0;
      end
    end else if (flags.in_triple) begin
      p_quote = flags.triple_dq ? CL_DQUOTE : CL_SQUOTE;
      if (la0 == CL_BSLASH) begin
        p_flags.skip = 2'd1;
      end else if (la0 == p_quote && p_has2 && la1 == p_quote && head_cls == p_quote) begin
        p_flags.in_triple = 1'b0;
        p_flags.skip      = 2'd2;
      end
    end else if (la0 == CL_HASH) begin
      p_flags.in_comment = 1'b1;
    end else if (la0 == CL_SPACE) begin
      p_flags.in_comment = 1'b0;
    end else if (la0 == CL_BSLASH && !p_has1) begin
      p_flags.line_bs = 1'b1;
    end else begin
      p_flags.line_token = 1'b1;
      p_flags.last_colon = 1'b0;
      case (la0)
        CL_DQUOTE, CL_SQUOTE: begin
          if (p_has2 && la1 == la0 && head_cls == la0) begin
            p_flags.in_triple = 1'b1;
            p_flags.triple_dq = la0 == CL_DQUOTE;
            p_flags.skip      = 2'd2;
          end else begin
            p_flags.in_plain = 1'b1;
            p_flags.plain_dq = la0 == CL_DQUOTE;
            p_flags.escape   = 1'b0;
          end
        end
        CL_OPEN: begin
          if (nest_depth != DEPTH_MAX) begin
            p_depth = nest_depth + DEPTH_BITS'(1);
          end
        end
        CL_CLOSE: begin
          if (nest_depth != '0) begin
            p_depth = nest_depth - DEPTH_BITS'(1);
          end
        end
        CL_EQUAL: begin
          if (nest_depth == '0) begin
            p_hit              = 1'b1;
            p_flags.last_colon = flags.last_colon;
          end
        end
        CL_COLON: begin
          p_flags.last_colon  = 1'b1;
          p_flags.colon_valid = 1'b1;
          p_colon_ln          = current_line;
          p_colon_col         = current_column;
        end
        default: begin
          p_flags.last_colon = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    flags_next          = flags;
    nest_depth_next     = nest_depth;
    colon_ln_next       = colon_ln;
    colon_col_next      = colon_col;
    current_line_next   = current_line;
    current_column_next = current_column;
    la0_next            = la0;
    la1_next            = la1;
    la_count_next       = la_count;
    take                = 1'b0;
    emit                = 1'b0;
    emit_found          = 1'b0;
    if (head_op == OP_START) begin
      flags_next           = '0;
      flags_next.searching = 1'b1;
      nest_depth_next      = '0;
      colon_ln_next        = '0;
      colon_col_next       = '0;
      current_line_next    = head_line;
      current_column_next  = head_column;
      la0_next             = CL_OTHER;
      la1_next             = CL_OTHER;
      la_count_next        = 2'd0;
      take                 = 1'b1;
    end else if (!flags.searching) begin
      take = 1'b1;
    end else if (head_op == OP_CHAR && la_count != 2'd2) begin
      if (la_count == 2'd0) begin
        la0_next = head_cls;
      end else begin
        la1_next = head_cls;
      end
      la_count_next = la_count + 2'd1;
      take          = 1'b1;
    end else if (la_count != 2'd0) begin
      flags_next          = p_flags;
      nest_depth_next     = p_depth;
      colon_ln_next       = p_colon_ln;
      colon_col_next      = p_colon_col;
      current_column_next = p_col;
      la0_next            = la1;
      if (head_op == OP_CHAR) begin
        la1_next = head_cls;
        take     = 1'b1;
      end else begin
        la_count_next = la_count - 2'd1;
      end
      if (p_hit) begin
        la_count_next        = 2'd0;
        flags_next.searching = 1'b0;
        emit                 = 1'b1;
        emit_found           = 1'b1;
        take                 = 1'b1;
      end
    end else if (head_op == OP_TEXT_END) begin
      flags_next.searching = 1'b0;
      emit                 = 1'b1;
      take                 = 1'b1;
    end else begin
      // end of a physical line with nothing held
      take                  = 1'b1;
      flags_next.in_comment = 1'b0;
      flags_next.in_plain   = 1'b0;
      flags_next.escape     = 1'b0;
      flags_next.skip       = 2'd0;
      if (!flags.in_triple) begin
        if (flags.line_bs) begin
          flags_next.continued = 1'b1;
        end else if (flags.line_token) begin
          flags_next.continued = 1'b0;
        end
        if (!flags_next.continued && nest_depth == '0) begin
          flags_next.searching = 1'b0;
          emit                 = 1'b1;
        end
      end
      flags_next.line_bs    = 1'b0;
      flags_next.line_token = 1'b0;
      current_line_next     = current_line + LINE_BITS'(1);
      current_column_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags          <= '0;
      nest_depth     <= '0;
      colon_ln       <= '0;
      colon_col      <= '0;
      current_line   <= '0;
      current_column <= '0;
      la0            <= CL_OTHER;
      la1            <= CL_OTHER;
      la_count       <= 2'd0;
    end else if (step) begin
      flags          <= flags_next;
      nest_depth     <= nest_depth_next;
      colon_ln       <= colon_ln_next;
      colon_col      <= colon_col_next;
      current_line   <= current_line_next;
      current_column <= current_column_next;
      la0            <= la0_next;
      la1            <= la1_next;
      la_count       <= la_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      found         <= emit_found;
      equal_line    <= emit_found ? current_line : '0;
      equal_column  <= emit_found ? current_column : '0;
      inferred      <= emit_found && flags.last_colon;
      colon_seen    <= flags_next.colon_valid;
      colon_ln_out  <= flags_next.colon_valid ? colon_ln_next : '0;
      colon_col_out <= flags_next.colon_valid ? colon_col_next : '0;
    end
  end

endmodule
